// ----- hdl/cubic_hermite_spline_eval_core_defines.svh -----
// assertion macros used by the multiply-divide unit of the spline evaluator rtl
// no dependencies
`ifndef CUBIC_HERMITE_SPLINE_EVAL_CORE_DEFINES_SVH
`define CUBIC_HERMITE_SPLINE_EVAL_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CHSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CHSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/chse_pkg.sv -----
// shared types, codes and constants of the cubic hermite spline evaluator
// no dependencies
package chse_pkg;

    localparam int MAX_KNOTS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int WIDE_W = 64;
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh1FFF_FFFF_FFFF_FFFF;

    localparam int KIDX_W     = 4;
    localparam int KC_W       = 5;
    localparam int SEG_OUT_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_UNIT = 1'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // knot table read slots
    localparam int NSLOT = 6;
    localparam logic [2:0] SLOT_LO0  = 3'd0;
    localparam logic [2:0] SLOT_HI0  = 3'd1;
    localparam logic [2:0] SLOT_LO1  = 3'd2;
    localparam logic [2:0] SLOT_HI1  = 3'd3;
    localparam logic [2:0] SLOT_SI   = 3'd4;
    localparam logic [2:0] SLOT_SI1  = 3'd5;
    localparam logic [2:0] SLOT_SRCH = 3'd6;

    // mul-div operand sets
    localparam logic [2:0] MD_M0 = 3'd0;
    localparam logic [2:0] MD_M1 = 3'd1;
    localparam logic [2:0] MD_U  = 3'd2;
    localparam logic [2:0] MD_H0 = 3'd3;
    localparam logic [2:0] MD_HA = 3'd4;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_LOAD  = 3'd1;
    localparam logic [2:0] ACC_ADD   = 3'd2;
    localparam logic [2:0] ACC_ST_A0 = 3'd3;
    localparam logic [2:0] ACC_ST_A1 = 3'd4;

    // accumulator sources
    localparam logic [3:0] SRC_D2  = 4'd0;
    localparam logic [3:0] SRC_D3  = 4'd1;
    localparam logic [3:0] SRC_M0  = 4'd2;
    localparam logic [3:0] SRC_NM0 = 4'd3;
    localparam logic [3:0] SRC_M1  = 4'd4;
    localparam logic [3:0] SRC_NM1 = 4'd5;
    localparam logic [3:0] SRC_A1  = 4'd6;
    localparam logic [3:0] SRC_P0  = 4'd7;
    localparam logic [3:0] SRC_MD  = 4'd8;

    typedef struct packed {
        logic       q_load;
        logic       knot_wr;
        logic       seg_init;
        logic       seg_dec;
        logic       rd_en;
        logic [2:0] rd_slot;
        logic       cap_en;
        logic       md_start;
        logic [2:0] md_sel;
        logic [2:0] acc_op;
        logic [3:0] acc_src;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic srch_go;
        logic err;
        logic md_done;
    } t_stat;

    function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W:0] s);
        logic signed [WIDE_W:0] hi;
        logic signed [WIDE_W:0] lo;
        hi = (WIDE_W+1)'(WIDE_MAX);
        lo = -hi;
        if (s > hi) begin
            return WIDE_MAX;
        end else if (s < lo) begin
            return -WIDE_MAX;
        end
        return WIDE_W'(s);
    endfunction

endpackage

// ----- hdl/chse_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module chse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/chse_muldiv.sv -----
// shared rounding multiply-divide unit: round(a * b / d) or round(a * b / 2^frac)
// 31x31 partial products summed one after another, then a bit-serial restoring divider
// depends on chse_pkg and the assertion macro header
`include "cubic_hermite_spline_eval_core_defines.svh"

module chse_muldiv import chse_pkg::*; #(
    parameter int D_W       = DATA_WIDTH_DEF + 1,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_shift,
    input  logic signed [WIDE_W-1:0] i_a,
    input  logic signed [WIDE_W-1:0] i_b,
    input  logic signed [D_W-1:0]    i_d,
    output logic                     o_done,
    output logic signed [WIDE_W-1:0] o_res
);

    localparam int MAG_W  = 62;
    localparam int HALF_W = 31;
    localparam int PROD_W = 2 * MAG_W;
    localparam int CNT_W  = $clog2(WIDE_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]               r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [MAG_W-1:0]         r_ma;
    logic [MAG_W-1:0]         r_mb;
    logic [D_W-1:0]           r_md;
    logic                     r_neg;
    logic                     r_shift;
    logic [PROD_W-1:0]        r_prod;
    logic [WIDE_W-1:0]        r_quo;
    logic [D_W-1:0]           r_rem;
    logic signed [WIDE_W-1:0] r_res;
    logic                     r_done;

    logic [WIDE_W-1:0]        abs_a;
    logic [WIDE_W-1:0]        abs_b;
    logic [HALF_W-1:0]        part_a;
    logic [HALF_W-1:0]        part_b;
    logic [2*HALF_W-1:0]      pp;
    logic [PROD_W-1:0]        pp_sh;
    logic [D_W:0]             rem_sh;
    logic                     ge;
    logic                     rnd;
    logic [WIDE_W:0]          q_shift;
    logic [WIDE_W:0]          q_div;

    function automatic logic signed [WIDE_W-1:0] sat_mag(input logic [WIDE_W:0] m,
                                                       input logic neg);
        logic signed [WIDE_W-1:0] r;
        r = (m > (WIDE_W+1)'(WIDE_MAX)) ? WIDE_MAX : WIDE_W'(m);
        return neg ? -r : r;
    endfunction

    always_comb begin
        abs_a  = i_a[WIDE_W-1] ? WIDE_W'(-i_a) : WIDE_W'(i_a);
        abs_b  = i_b[WIDE_W-1] ? WIDE_W'(-i_b) : WIDE_W'(i_b);
        part_a = r_cnt[0] ? r_ma[MAG_W-1:HALF_W] : r_ma[HALF_W-1:0];
        part_b = r_cnt[1] ? r_mb[MAG_W-1:HALF_W] : r_mb[HALF_W-1:0];
        pp     = part_a * part_b;
        pp_sh  = PROD_W'(pp) << (HALF_W * (int'(r_cnt[0]) + int'(r_cnt[1])));
        rem_sh = {r_rem, r_quo[WIDE_W-1]};
        ge     = (rem_sh >= {1'b0, r_md});
        rnd    = ({r_rem, 1'b0} >= {1'b0, r_md});
        q_shift = (WIDE_W+1)'(r_prod[WIDE_W-1:FRAC_BITS])
                + (WIDE_W+1)'(r_prod[FRAC_BITS-1]);
        q_div   = (WIDE_W+1)'(r_quo) + (WIDE_W+1)'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_ma    <= abs_a[MAG_W-1:0];
                        r_mb    <= abs_b[MAG_W-1:0];
                        r_md    <= i_d[D_W-1] ? D_W'(-i_d) : D_W'(i_d);
                        r_neg   <= i_a[WIDE_W-1] ^ i_b[WIDE_W-1] ^ (i_d[D_W-1] & ~i_shift);
                        r_shift <= i_shift;
                        r_prod  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod <= r_prod + pp_sh;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_cnt <= '0;
                    if (r_ma == '0 || r_mb == '0) begin
                        r_res   <= '0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (|r_prod[PROD_W-1:WIDE_W]) begin
                        // product overflows 64 bits
                        r_res   <= r_neg ? -WIDE_MAX : WIDE_MAX;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (r_shift) begin
                        r_res   <= sat_mag(q_shift, r_neg);
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_quo   <= r_prod[WIDE_W-1:0];
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= ge ? D_W'(rem_sh - {1'b0, r_md}) : D_W'(rem_sh);
                    r_quo <= {r_quo[WIDE_W-2:0], ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(WIDE_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_res   <= sat_mag(q_div, r_neg);
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `CHSE_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE, "start while busy")
    `CHSE_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held over two cycles")
    `CHSE_ASSERT_IMP(a_res_range, i_clk, i_rst_n, r_done,
        (r_res <= WIDE_MAX) && (r_res >= -WIDE_MAX), "result outside saturation range")

endmodule

// ----- hdl/chse_ctrl.sv -----
// controller of the spline evaluator: handshakes, segment search, knot reads
// and the step sequence of the arithmetic; depends on chse_pkg
module chse_ctrl import chse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_command,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRCH_A  = 4'd1;
    localparam logic [3:0] S_SRCH_C  = 4'd2;
    localparam logic [3:0] S_RD_A    = 4'd3;
    localparam logic [3:0] S_RD_C    = 4'd4;
    localparam logic [3:0] S_CHK     = 4'd5;
    localparam logic [3:0] S_STEP    = 4'd6;
    localparam logic [3:0] S_MD_WAIT = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [2:0]        r_slot;
    logic [2:0]        n_slot;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;

    logic       st_md;
    logic [2:0] st_md_sel;
    logic [2:0] st_acc_op;
    logic [3:0] st_acc_src;
    logic       fire;

    // step program: three mul-divs, coefficient sums, then horner
    always_comb begin
        st_md      = 1'b0;
        st_md_sel  = MD_M0;
        st_acc_op  = ACC_HOLD;
        st_acc_src = SRC_D2;
        unique case (r_step)
            5'd0:  begin st_md = 1'b1; st_md_sel = MD_M0; end
            5'd1:  begin st_md = 1'b1; st_md_sel = MD_M1; end
            5'd2:  begin st_md = 1'b1; st_md_sel = MD_U;  end
            5'd3:  begin st_acc_op = ACC_LOAD; st_acc_src = SRC_D2;  end
            5'd4:  begin st_acc_op = ACC_ADD;  st_acc_src = SRC_M0;  end
            5'd5:  begin st_acc_op = ACC_ADD;  st_acc_src = SRC_M1;  end
            5'd6:  begin st_acc_op = ACC_ST_A0; end
            5'd7:  begin st_acc_op = ACC_LOAD; st_acc_src = SRC_D3;  end
            5'd8:  begin st_acc_op = ACC_ADD;  st_acc_src = SRC_NM0; end
            5'd9:  begin st_acc_op = ACC_ADD;  st_acc_src = SRC_NM0; end
            5'd10: begin st_acc_op = ACC_ADD;  st_acc_src = SRC_NM1; end
            5'd11: begin st_acc_op = ACC_ST_A1; end
            5'd12: begin st_md = 1'b1; st_md_sel = MD_H0; end
            5'd13: begin st_acc_op = ACC_LOAD; st_acc_src = SRC_MD;  end
            5'd14: begin st_acc_op = ACC_ADD;  st_acc_src = SRC_A1;  end
            5'd15: begin st_md = 1'b1; st_md_sel = MD_HA; end
            5'd16: begin st_acc_op = ACC_LOAD; st_acc_src = SRC_MD;  end
            5'd17: begin st_acc_op = ACC_ADD;  st_acc_src = SRC_M0;  end
            5'd18: begin st_md = 1'b1; st_md_sel = MD_HA; end
            5'd19: begin st_acc_op = ACC_LOAD; st_acc_src = SRC_MD;  end
            5'd20: begin st_acc_op = ACC_ADD;  st_acc_src = SRC_P0;  end
            default: begin end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign fire       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.md_sel  = st_md_sel;
        o_cmd.acc_src = st_acc_src;
        o_cmd.rd_slot = r_slot;
        n_state     = r_state;
        n_slot      = r_slot;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (fire) begin
                    if (i_command == CMD_EVAL) begin
                        o_cmd.q_load   = 1'b1;
                        o_cmd.seg_init = 1'b1;
                        n_state        = S_SRCH_A;
                    end else begin
                        o_cmd.knot_wr = 1'b1;
                    end
                end
            end
            S_SRCH_A: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_slot = SLOT_SRCH;
                n_state       = S_SRCH_C;
            end
            S_SRCH_C: begin
                o_cmd.rd_slot = SLOT_SRCH;
                if (i_stat.srch_go) begin
                    o_cmd.seg_dec = 1'b1;
                    n_state       = S_SRCH_A;
                end else begin
                    n_slot  = SLOT_LO0;
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD_C;
            end
            S_RD_C: begin
                o_cmd.cap_en = 1'b1;
                if (r_slot == SLOT_SI1) begin
                    n_state = S_CHK;
                end else begin
                    n_slot  = r_slot + 3'd1;
                    n_state = S_RD_A;
                end
            end
            S_CHK: begin
                n_step  = '0;
                n_state = i_stat.err ? S_DONE : S_STEP;
            end
            S_STEP: begin
                if (st_md) begin
                    o_cmd.md_start = 1'b1;
                    n_state        = S_MD_WAIT;
                end else begin
                    o_cmd.acc_op = st_acc_op;
                    if (r_step == LAST_STEP) begin
                        n_state = S_DONE;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
            S_MD_WAIT: begin
                if (i_stat.md_done) begin
                    n_step  = r_step + STEP_W'(1);
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                // a waiting result must be taken before the next one is loaded
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= SLOT_LO0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/chse_dp.sv -----
// datapath of the spline evaluator: knot table, configuration, segment index,
// operand registers, accumulator and output register; depends on chse_pkg,
// chse_ram and chse_muldiv
module chse_dp import chse_pkg::*; #(
    parameter int MAX_KNOTS  = MAX_KNOTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic [KIDX_W-1:0]            i_knot_index,
    input  logic signed [DATA_WIDTH-1:0] i_knot_position,
    input  logic signed [DATA_WIDTH-1:0] i_knot_value,
    input  logic signed [DATA_WIDTH-1:0] i_query_position,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic signed [DATA_WIDTH-1:0] o_spline_value,
    output logic [SEG_OUT_W-1:0]         o_segment_used,
    output logic                         o_error_status
);

    localparam int DW    = DATA_WIDTH;
    localparam int D_W   = DW + 1;
    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int CW    = (IDX_W + 1 > KC_W) ? IDX_W + 1 : KC_W;
    localparam logic signed [WIDE_W-1:0] ONE_Q = WIDE_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] VMAX  = (WIDE_W'(1) << (DW - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] VMIN  = -VMAX - WIDE_W'(1);

    logic [KC_W-1:0]          r_knot_count;
    logic                     r_clamp;
    logic signed [DW-1:0]     r_q;
    logic [IDX_W-1:0]         r_seg;
    logic signed [DW-1:0]     r_tk [NSLOT];
    logic signed [DW-1:0]     r_vk [NSLOT];
    logic signed [WIDE_W-1:0] r_m0;
    logic signed [WIDE_W-1:0] r_m1;
    logic signed [WIDE_W-1:0] r_u;
    logic signed [WIDE_W-1:0] r_md;
    logic signed [WIDE_W-1:0] r_a0;
    logic signed [WIDE_W-1:0] r_a1;
    logic signed [WIDE_W-1:0] r_acc;
    logic signed [DW-1:0]     r_val;
    logic [SEG_OUT_W-1:0]     r_seg_out;
    logic                     r_err_out;

    logic [CW-1:0]            kc_ext;
    logic [CW-1:0]            n_knots;
    logic [IDX_W-1:0]         m_int;
    logic [IDX_W-1:0]         seg_p1;
    logic                     last1;
    logic [IDX_W-1:0]         raddr;
    logic                     wr_ok;
    logic [2*DW-1:0]          ram_rdata;
    logic signed [DW-1:0]     t_dout;
    logic signed [DW-1:0]     v_dout;
    logic signed [D_W-1:0]    h;
    logic signed [D_W-1:0]    dt0;
    logic signed [D_W-1:0]    dt1;
    logic signed [D_W-1:0]    dg0;
    logic signed [D_W-1:0]    dg1;
    logic signed [D_W-1:0]    qd;
    logic signed [D_W-1:0]    dp01;
    logic signed [D_W-1:0]    dp10;
    logic                     err;
    logic signed [WIDE_W-1:0] md_a;
    logic signed [WIDE_W-1:0] md_b;
    logic signed [D_W-1:0]    md_d;
    logic                     md_shift;
    logic                     md_done;
    logic signed [WIDE_W-1:0] md_res;
    logic signed [WIDE_W-1:0] src;
    logic signed [WIDE_W-1:0] sum;
    logic signed [WIDE_W-1:0] fin;
    logic signed [DW-1:0]     val;

    // knot count limited to the table
    always_comb begin
        kc_ext  = CW'(r_knot_count);
        n_knots = (kc_ext < CW'(2)) ? CW'(2)
                : (kc_ext > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : kc_ext;
        m_int   = IDX_W'(n_knots - CW'(1));
        wr_ok   = CW'(i_knot_index) < CW'(MAX_KNOTS);
    end

    always_comb begin
        seg_p1 = r_seg + IDX_W'(1);
        last1  = (seg_p1 >= m_int);
        unique case (i_cmd.rd_slot)
            SLOT_LO0: raddr = (r_seg == '0) ? '0 : r_seg - IDX_W'(1);
            SLOT_HI0: raddr = (r_seg == '0) ? IDX_W'(1) : seg_p1;
            SLOT_LO1: raddr = last1 ? m_int - IDX_W'(1) : r_seg;
            SLOT_HI1: raddr = last1 ? m_int : r_seg + IDX_W'(2);
            SLOT_SI1: raddr = seg_p1;
            default:  raddr = r_seg;
        endcase
    end

    chse_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_KNOTS)
    ) u_knot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.knot_wr && wr_ok),
        .i_waddr (IDX_W'(i_knot_index)),
        .i_wdata ({i_knot_position, i_knot_value}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign t_dout = ram_rdata[2*DW-1:DW];
    assign v_dout = ram_rdata[DW-1:0];

    always_comb begin
        h    = D_W'(r_tk[SLOT_SI1]) - D_W'(r_tk[SLOT_SI]);
        dt0  = D_W'(r_tk[SLOT_HI0]) - D_W'(r_tk[SLOT_LO0]);
        dt1  = D_W'(r_tk[SLOT_HI1]) - D_W'(r_tk[SLOT_LO1]);
        dg0  = D_W'(r_vk[SLOT_HI0]) - D_W'(r_vk[SLOT_LO0]);
        dg1  = D_W'(r_vk[SLOT_HI1]) - D_W'(r_vk[SLOT_LO1]);
        qd   = D_W'(r_q) - D_W'(r_tk[SLOT_SI]);
        dp01 = D_W'(r_vk[SLOT_SI]) - D_W'(r_vk[SLOT_SI1]);
        dp10 = D_W'(r_vk[SLOT_SI1]) - D_W'(r_vk[SLOT_SI]);
        err  = (h == '0) || (dt0 == '0) || (dt1 == '0);
    end

    always_comb begin
        md_shift = (i_cmd.md_sel == MD_H0) || (i_cmd.md_sel == MD_HA);
        unique case (i_cmd.md_sel)
            MD_M0: begin md_a = WIDE_W'(dg0); md_b = WIDE_W'(h); md_d = dt0; end
            MD_M1: begin md_a = WIDE_W'(dg1); md_b = WIDE_W'(h); md_d = dt1; end
            MD_U:  begin md_a = WIDE_W'(qd);  md_b = ONE_Q;      md_d = h;   end
            MD_H0: begin md_a = r_a0;         md_b = r_u;        md_d = h;   end
            default: begin md_a = r_acc;      md_b = r_u;        md_d = h;   end
        endcase
    end

    chse_muldiv #(
        .D_W       (D_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_shift (md_shift),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    always_comb begin
        unique case (i_cmd.acc_src)
            SRC_D2:  src = WIDE_W'(dp01) <<< 1;
            SRC_D3:  src = (WIDE_W'(dp10) <<< 1) + WIDE_W'(dp10);
            SRC_M0:  src = r_m0;
            SRC_NM0: src = -r_m0;
            SRC_M1:  src = r_m1;
            SRC_NM1: src = -r_m1;
            SRC_A1:  src = r_a1;
            SRC_P0:  src = WIDE_W'(r_vk[SLOT_SI]);
            default: src = r_md;
        endcase
        sum = sat_wide((WIDE_W+1)'(r_acc) + (WIDE_W+1)'(src));
    end

    // optional unit clamp, then saturation to the output width
    always_comb begin
        fin = r_acc;
        if (r_clamp) begin
            if (fin < 0) begin
                fin = '0;
            end else if (fin > ONE_Q) begin
                fin = ONE_Q;
            end
        end
        if (fin > VMAX) begin
            fin = VMAX;
        end else if (fin < VMIN) begin
            fin = VMIN;
        end
        val = DW'(fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= KC_W'(2);
            r_clamp      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KNOT_COUNT: r_knot_count <= i_cfg_data[KC_W-1:0];
                REG_CLAMP_UNIT: r_clamp      <= i_cfg_data[0];
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_q <= i_query_position;
        end
        if (i_cmd.seg_init) begin
            r_seg <= m_int - IDX_W'(1);
        end else if (i_cmd.seg_dec) begin
            r_seg <= r_seg - IDX_W'(1);
        end
        if (i_cmd.cap_en) begin
            r_tk[i_cmd.rd_slot] <= t_dout;
            r_vk[i_cmd.rd_slot] <= v_dout;
        end
        if (md_done) begin
            unique case (i_cmd.md_sel)
                MD_M0:   r_m0 <= md_res;
                MD_M1:   r_m1 <= md_res;
                MD_U:    r_u  <= md_res;
                default: r_md <= md_res;
            endcase
        end
        unique case (i_cmd.acc_op)
            ACC_LOAD:  r_acc <= src;
            ACC_ADD:   r_acc <= sum;
            ACC_ST_A0: r_a0  <= r_acc;
            ACC_ST_A1: r_a1  <= r_acc;
            default: begin end
        endcase
        if (i_cmd.out_load) begin
            r_val     <= err ? '0 : val;
            r_seg_out <= SEG_OUT_W'(r_seg);
            r_err_out <= err;
        end
    end

    assign o_stat.srch_go = (r_seg != '0) && (r_q < t_dout);
    assign o_stat.err     = err;
    assign o_stat.md_done = md_done;

    assign o_spline_value = r_val;
    assign o_segment_used = r_seg_out;
    assign o_error_status = r_err_out;

endmodule

// ----- hdl/cubic_hermite_spline_eval_core.sv -----
// an evaluate runs from acceptance to output valid through a top-down segment search, the knot
// reads and the steps on the shared multiply-divide unit: three divides (64-step bit-serial
// divider) and three scaled multiplies; a zero operand cuts a divide short
// a zero-width interval ends the evaluate after the knot reads; a knot write is done on
// acceptance and gives no result; one transaction at a time, a full output register stalls the end
// synchronous active-low reset sets knot_count to 2 and clamp_unit to 0, clears control
// state and the output valid; the knot table holds no reset value
module cubic_hermite_spline_eval_core import chse_pkg::*; #(
    parameter int MAX_KNOTS  = MAX_KNOTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [KIDX_W-1:0]            i_knot_index,
    input  logic signed [DATA_WIDTH-1:0] i_knot_position,
    input  logic signed [DATA_WIDTH-1:0] i_knot_value,
    input  logic signed [DATA_WIDTH-1:0] i_query_position,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_spline_value,
    output logic [SEG_OUT_W-1:0]         o_segment_used,
    output logic                         o_error_status,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    chse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    chse_dp #(
        .MAX_KNOTS  (MAX_KNOTS),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_knot_index     (i_knot_index),
        .i_knot_position  (i_knot_position),
        .i_knot_value     (i_knot_value),
        .i_query_position (i_query_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_spline_value   (o_spline_value),
        .o_segment_used   (o_segment_used),
        .o_error_status   (o_error_status)
    );

endmodule

// ----- test/tb_cubic_hermite_spline_eval_core.sv -----
// self-checking testbench for cubic_hermite_spline_eval_core: loads knot tables, evaluates
// queries and compares every result with a cycle-free fixed-point spline predictor
// depends on chse_pkg and the core rtl
module tb_cubic_hermite_spline_eval_core;
    import chse_pkg::*;

    typedef struct {
        logic                cmd;
        logic [KIDX_W-1:0]   idx;
        logic signed [15:0]  pos;
        logic signed [15:0]  val;
        logic signed [15:0]  qry;
    } t_item;

    typedef struct {
        logic signed [15:0]     value;
        logic [SEG_OUT_W-1:0]   seg;
        logic                   err;
    } t_spline_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    logic cmd = CMD_WRITE;
    logic [KIDX_W-1:0] kidx = '0;
    logic signed [15:0] kpos_in = '0;
    logic signed [15:0] kval_in = '0;
    logic signed [15:0] qry_in = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] o_spline_value;
    logic [SEG_OUT_W-1:0] o_segment_used;
    logic o_error_status;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_KNOT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_item pending_items[$];
    t_spline_res spline_want[$];
    int fail_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    logic in_fire = 1'b0;
    int kc_list[10] = '{16, 2, 0, 1, 5, 31, 17, 9, 16, 3};

    // predictor state
    logic signed [63:0] tbl_pos[16];
    logic signed [63:0] tbl_val[16];
    logic [4:0] knots_in_use = 5'd2;
    logic clamp_on = 1'b0;

    cubic_hermite_spline_eval_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_command(cmd), .i_knot_index(kidx), .i_knot_position(kpos_in),
        .i_knot_value(kval_in), .i_query_position(qry_in),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_spline_value(o_spline_value), .o_segment_used(o_segment_used),
        .o_error_status(o_error_status),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
        logic signed [63:0] r;
        r = (m > 64'(WIDE_MAX)) ? WIDE_MAX : $signed(m);
        return neg ? -r : r;
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(WIDE_MAX)) return WIDE_MAX;
        if (s < -65'(WIDE_MAX)) return -WIDE_MAX;
        return 64'(s);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] frac_mul(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic [127:0] p;
        logic neg;
        neg = (a < 0) != (b < 0);
        if (a == 0 || b == 0) return 0;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        if (p[127:64] != 0) return sat_mag('1, neg);
        p = (p >> FRAC_BITS_DEF) + ((p >> (FRAC_BITS_DEF - 1)) & 128'd1);
        return sat_mag(p[63:0], neg);
    endfunction

    function automatic logic signed [63:0] scale_div(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input logic signed [63:0] d);
        logic [127:0] p;
        logic [63:0] md, qt, rm;
        logic neg;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        if (a == 0 || b == 0) return 0;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        if (p[127:64] != 0) return sat_mag('1, neg);
        md = abs64(d);
        qt = p[63:0] / md;
        rm = p[63:0] % md;
        if (rm >= md - rm) qt = qt + 1;
        return sat_mag(qt, neg);
    endfunction

    // knot slope times interval width: one-sided at the ends, central inside
    function automatic logic signed [63:0] knot_tangent(input int k, input int nseg,
                                                        input logic signed [63:0] h,
                                                        inout logic err);
        int lo, hi;
        logic signed [63:0] dt;
        if (k == 0) begin
            lo = 0; hi = 1;
        end else if (k >= nseg) begin
            lo = nseg - 1; hi = nseg;
        end else begin
            lo = k - 1; hi = k + 1;
        end
        dt = tbl_pos[hi] - tbl_pos[lo];
        if (dt == 0) begin
            err = 1'b1;
            return 0;
        end
        return scale_div(tbl_val[hi] - tbl_val[lo], h, dt);
    endfunction

    function automatic t_spline_res eval_spline(input logic signed [15:0] qpos);
        t_spline_res res;
        int n, nseg, seg;
        logic signed [63:0] q, h, p0, p1, t0, t1, a0, a1, u, acc;
        logic err;
        err = 1'b0;
        n = knots_in_use;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        nseg = n - 1;
        q = 64'(qpos);
        seg = nseg - 1;
        while (seg > 0 && q < tbl_pos[seg]) seg--;
        h = tbl_pos[seg + 1] - tbl_pos[seg];
        acc = 0;
        if (h == 0) begin
            err = 1'b1;
        end else begin
            t0 = knot_tangent(seg, nseg, h, err);
            t1 = knot_tangent(seg + 1, nseg, h, err);
            if (!err) begin
                p0 = tbl_val[seg];
                p1 = tbl_val[seg + 1];
                a0 = add_sat(add_sat(2 * (p0 - p1), t0), t1);
                a1 = add_sat(add_sat(add_sat(3 * (p1 - p0), -t0), -t0), -t1);
                u = scale_div(q - tbl_pos[seg], 64'sd1 << FRAC_BITS_DEF, h);
                acc = add_sat(frac_mul(a0, u), a1);
                acc = add_sat(frac_mul(acc, u), t0);
                acc = add_sat(frac_mul(acc, u), p0);
                if (clamp_on) begin
                    if (acc < 0) acc = 0;
                    if (acc > (64'sd1 << FRAC_BITS_DEF)) acc = 64'sd1 << FRAC_BITS_DEF;
                end
                if (acc > 64'sd32767) acc = 64'sd32767;
                if (acc < -64'sd32768) acc = -64'sd32768;
            end
        end
        res.value = 16'(acc);
        res.seg = SEG_OUT_W'(seg);
        res.err = err;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // driver: new transaction at the falling edge once the previous one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_fire) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    cmd <= it.cmd;
                    kidx <= it.idx;
                    kpos_in <= it.pos;
                    kval_in <= it.val;
                    qry_in <= it.qry;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // input side: update the predictor on each accepted transaction
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_valid && o_in_ready;
        if (i_rst_n && in_valid && o_in_ready) begin
            if (cmd == CMD_WRITE) begin
                tbl_pos[kidx] = 64'(kpos_in);
                tbl_val[kidx] = 64'(kval_in);
            end else begin
                spline_want.push_back(eval_spline(qry_in));
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (spline_want.size() == 0) begin
                report_mismatch("unexpected result, segment", o_segment_used, 0);
            end else begin
                t_spline_res w;
                w = spline_want.pop_front();
                if (o_spline_value !== w.value)
                    report_mismatch("spline_value", o_spline_value, w.value);
                if (o_segment_used !== w.seg)
                    report_mismatch("segment_used", o_segment_used, w.seg);
                if (o_error_status !== w.err)
                    report_mismatch("error_status", o_error_status, w.err);
            end
        end
    end

    initial begin
        #(12 * 4_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic t_item knot_item(input int slot, input int p, input int v);
        t_item it;
        it.cmd = CMD_WRITE;
        it.idx = KIDX_W'(slot);
        it.pos = 16'(p);
        it.val = 16'(v);
        it.qry = 16'($urandom);
        return it;
    endfunction

    function automatic t_item query_item(input int q);
        t_item it;
        it.cmd = CMD_EVAL;
        it.idx = KIDX_W'($urandom);
        it.pos = 16'($urandom);
        it.val = 16'($urandom);
        it.qry = 16'(q);
        return it;
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        if (idx == REG_KNOT_COUNT) knots_in_use = 5'(value);
        else clamp_on = value[0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !in_valid && spline_want.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // increasing knot table with random content, then queries over and beyond it
    task automatic push_table_and_queries(input int n, output int cnt);
        int start, stepmax, p, k, nq, kv;
        start = $urandom_range(0, 24000) - 32768;
        stepmax = (32767 - start) / (n - 1);
        if ($urandom_range(0, 3) == 0 && stepmax > 64) stepmax = 64;
        p = start;
        cnt = 0;
        for (k = 0; k < n; k++) begin
            kv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) - 32768
                                             : $urandom_range(0, 8192) - 2048;
            pending_items.push_back(knot_item(k, p, kv));
            p = p + $urandom_range(1, stepmax);
            cnt++;
        end
        nq = $urandom_range(2, 8);
        for (k = 0; k < nq; k++) begin
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(query_item($urandom_range(0, 65535) - 32768));
            else
                pending_items.push_back(query_item(start + $urandom_range(0, 32767 - start)));
            cnt++;
        end
    endtask

    task automatic push_random(input int want_items);
        int done, c, n;
        done = 0;
        n = knots_in_use;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        while (done < want_items) begin
            if ($urandom_range(0, 99) < 80) begin
                push_table_and_queries(n, c);
                done += c;
            end else if ($urandom_range(0, 1) == 0) begin
                // stray write: may leave duplicate or falling knots
                pending_items.push_back(knot_item($urandom_range(0, 15),
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768));
                done++;
            end else begin
                pending_items.push_back(query_item($urandom_range(0, 65535) - 32768));
                done++;
            end
        end
    endtask

    initial begin
        int ph, k;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        knots_in_use = 5'd2;
        clamp_on = 1'b0;

        // directed: full table with extreme values, queries at edges, at knots and between knots
        set_reg(REG_KNOT_COUNT, 16);
        for (k = 0; k < 16; k++)
            pending_items.push_back(knot_item(k, -30000 + k * 4000,
                (k % 2 == 0) ? 32767 : -32768));
        pending_items.push_back(query_item(-32768));
        pending_items.push_back(query_item(32767));
        pending_items.push_back(query_item(-30000));
        pending_items.push_back(query_item(30000));
        pending_items.push_back(query_item(-10000 + 2000));
        pending_items.push_back(query_item(0));
        wait_idle();
        set_reg(REG_CLAMP_UNIT, 1);
        // zero-width interval and a falling knot
        pending_items.push_back(knot_item(1, -30000, 100));
        pending_items.push_back(query_item(-1000));
        pending_items.push_back(knot_item(7, -7000, 100));
        pending_items.push_back(query_item(-3000));
        pending_items.push_back(query_item(-32768));
        wait_idle();

        for (ph = 0; ph < 10; ph++) begin
            set_reg(REG_KNOT_COUNT, kc_list[ph]);
            set_reg(REG_CLAMP_UNIT, ph % 2);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            push_random(90);
            // sender holds off until every result is back
            wait_idle();
            push_random(90);
            wait_idle();
        end

        repeat (300) @(posedge i_clk);
        if (spline_want.size() != 0)
            report_mismatch("results still pending", spline_want.size(), 0);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
